### rtl/sse_pkg.sv
// Shared types and constants for the sparse small-entry drop block.
`default_nettype none

package sse_pkg;

  localparam int unsigned RowW  = 16;
  localparam int unsigned ColW  = 16;
  localparam int unsigned NColW = 17;
  localparam int unsigned PosW  = 21;
  localparam int unsigned ValW  = 32;
  localparam int unsigned TolW  = 31;
  localparam int unsigned SqW   = 63;
  localparam int unsigned AddrW = 4;

  localparam int unsigned MAX_DIM     = 65536;
  localparam int unsigned MAX_ENTRIES = 1048576;

  // Stream actions
  localparam logic [1:0] ACT_COLUMN = 2'd0;
  localparam logic [1:0] ACT_ENTRY  = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // Symmetry modes
  localparam logic [1:0] SYM_UPPER = 2'd1;
  localparam logic [1:0] SYM_LOWER = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_TOLERANCE = 2'd0;
  localparam logic [1:0] REG_SYMMETRY  = 2'd1;
  localparam logic [1:0] REG_COMPLEX   = 2'd2;

  // Result kinds
  localparam logic KIND_POINTER = 1'b0;
  localparam logic KIND_ENTRY   = 1'b1;

  typedef struct packed {
    logic [TolW-1:0] tolerance;
    logic [1:0]      sym_mode;
    logic            complex_mode;
  } cfg_t;

  typedef struct packed {
    logic            entry;
    logic            finish;
    logic [RowW-1:0] row;
    logic [ValW-1:0] re;
    logic [ValW-1:0] im;
    logic [ValW-1:0] mag_re;
    logic [ValW-1:0] mag_im;
  } s1_t;

  typedef struct packed {
    logic            entry;
    logic            finish;
    logic [RowW-1:0] row;
    logic [ValW-1:0] re;
    logic [ValW-1:0] im;
    logic            real_drop;
    logic [SqW-1:0]  sq_re;
    logic [SqW-1:0]  sq_im;
  } s2_t;

endpackage

`default_nettype wire

### rtl/sse_front.sv
// Input stage: column tracking, symmetry filter and magnitude of each entry.
`default_nettype none

module sse_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire sse_pkg::cfg_t              cfg_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic [sse_pkg::RowW-1:0]   row_index_i,
  input  wire logic [sse_pkg::ValW-1:0]   value_re_i,
  input  wire logic [sse_pkg::ValW-1:0]   value_im_i,
  output logic                            s1_valid_o,
  input  wire logic                       s1_ready_i,
  output sse_pkg::s1_t                    s1_o
);

  logic [sse_pkg::NColW-1:0] next_col_q, next_col_d;
  logic [sse_pkg::ColW-1:0]  cur_col_q, cur_col_d;
  logic                      s1_valid_q, s1_valid_d;
  sse_pkg::s1_t              s1_q, s1_d;
  logic                      accept, is_entry, is_column, is_finish, sym_drop, load;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_entry   = (action_i == sse_pkg::ACT_ENTRY);
  assign is_column  = (action_i == sse_pkg::ACT_COLUMN);
  assign is_finish  = (action_i == sse_pkg::ACT_FINISH);

  always_comb begin
    sym_drop = 1'b0;
    if (is_entry) begin
      if (cfg_i.sym_mode == sse_pkg::SYM_UPPER) begin
        sym_drop = (row_index_i > cur_col_q);
      end else if (cfg_i.sym_mode == sse_pkg::SYM_LOWER) begin
        sym_drop = (row_index_i < cur_col_q);
      end
    end
  end

  // Action three and entries outside the kept triangle never enter the pipe.
  assign load = (is_column || is_finish || is_entry) && !sym_drop;

  always_comb begin
    next_col_d = next_col_q;
    cur_col_d  = cur_col_q;
    if (accept) begin
      if (is_column && (next_col_q < sse_pkg::NColW'(sse_pkg::MAX_DIM))) begin
        cur_col_d  = next_col_q[sse_pkg::ColW-1:0];
        next_col_d = next_col_q + sse_pkg::NColW'(1);
      end else if (is_finish) begin
        cur_col_d  = '0;
        next_col_d = '0;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (in_ready_o) begin
      s1_valid_d = accept && load;
    end
    if (accept && load) begin
      s1_d.entry  = is_entry;
      s1_d.finish = is_finish;
      s1_d.row    = row_index_i;
      s1_d.re     = value_re_i;
      s1_d.im     = value_im_i;
      s1_d.mag_re = value_re_i[sse_pkg::ValW-1] ? (~value_re_i + sse_pkg::ValW'(1))
                                                 : value_re_i;
      s1_d.mag_im = value_im_i[sse_pkg::ValW-1] ? (~value_im_i + sse_pkg::ValW'(1))
                                                 : value_im_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_col_q <= '0;
      cur_col_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      next_col_q <= next_col_d;
      cur_col_q  <= cur_col_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

`default_nettype wire

### rtl/sse_square.sv
// Square stage: squares of both magnitudes and the real-mode tolerance compare.
`default_nettype none

module sse_square (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sse_pkg::cfg_t cfg_i,
  input  wire logic          s1_valid_i,
  output logic               s1_ready_o,
  input  wire sse_pkg::s1_t  s1_i,
  output logic               s2_valid_o,
  input  wire logic          s2_ready_i,
  output sse_pkg::s2_t       s2_o
);

  logic         s2_valid_q;
  sse_pkg::s2_t s2_q;
  logic [2*sse_pkg::ValW-1:0] prod_re, prod_im;

  assign s1_ready_o = !s2_valid_q || s2_ready_i;

  assign prod_re = {{sse_pkg::ValW{1'b0}}, s1_i.mag_re} * {{sse_pkg::ValW{1'b0}}, s1_i.mag_re};
  assign prod_im = {{sse_pkg::ValW{1'b0}}, s1_i.mag_im} * {{sse_pkg::ValW{1'b0}}, s1_i.mag_im};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready_o && s1_valid_i) begin
      s2_q.entry     <= s1_i.entry;
      s2_q.finish    <= s1_i.finish;
      s2_q.row       <= s1_i.row;
      s2_q.re        <= s1_i.re;
      s2_q.im        <= s1_i.im;
      s2_q.real_drop <= (s1_i.mag_re <= {1'b0, cfg_i.tolerance});
      s2_q.sq_re     <= prod_re[sse_pkg::SqW-1:0];
      s2_q.sq_im     <= prod_im[sse_pkg::SqW-1:0];
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

endmodule

`default_nettype wire

### rtl/sse_back.sv
// Result stage: magnitude decision, kept-entry counter and result register.
`default_nettype none

module sse_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sse_pkg::cfg_t            cfg_i,
  input  wire logic                     s2_valid_i,
  output logic                          s2_ready_o,
  input  wire sse_pkg::s2_t             s2_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          result_kind_o,
  output logic [sse_pkg::PosW-1:0]      position_o,
  output logic [sse_pkg::RowW-1:0]      row_out_o,
  output logic [sse_pkg::ValW-1:0]      re_out_o,
  output logic [sse_pkg::ValW-1:0]      im_out_o
);

  localparam int unsigned TolSqW = 2 * sse_pkg::TolW;
  localparam int unsigned SumW   = sse_pkg::SqW + 1;

  logic [TolSqW-1:0]       tol_sq_q;
  logic [sse_pkg::PosW-1:0] kept_q, kept_d;
  logic                    out_valid_q, out_valid_d;
  logic                    kind_q;
  logic [sse_pkg::PosW-1:0] pos_q;
  logic [sse_pkg::RowW-1:0] row_q;
  logic [sse_pkg::ValW-1:0] re_q, im_q;
  logic [SumW-1:0]         sq_sum;
  logic                    fire, drop, room, keep, has_result;

  assign s2_ready_o = !out_valid_q || out_ready_i;
  assign fire       = s2_valid_i && s2_ready_o;

  assign sq_sum = {1'b0, s2_i.sq_re} + {1'b0, s2_i.sq_im};
  assign drop   = cfg_i.complex_mode ? (sq_sum <= {{(SumW-TolSqW){1'b0}}, tol_sq_q})
                                     : s2_i.real_drop;
  assign room       = (kept_q < sse_pkg::PosW'(sse_pkg::MAX_ENTRIES));
  assign keep       = s2_i.entry && !drop && room;
  assign has_result = !s2_i.entry || keep;

  always_comb begin
    kept_d      = kept_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire) begin
      out_valid_d = has_result;
      if (s2_i.finish) begin
        kept_d = '0;
      end else if (keep) begin
        kept_d = kept_q + sse_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_sq_q    <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tol_sq_q    <= {{sse_pkg::TolW{1'b0}}, cfg_i.tolerance}
                   * {{sse_pkg::TolW{1'b0}}, cfg_i.tolerance};
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_result) begin
      pos_q <= kept_q;
      if (s2_i.entry) begin
        kind_q <= sse_pkg::KIND_ENTRY;
        row_q  <= s2_i.row;
        re_q   <= s2_i.re;
        im_q   <= cfg_i.complex_mode ? s2_i.im : '0;
      end else begin
        kind_q <= sse_pkg::KIND_POINTER;
        row_q  <= '0;
        re_q   <= '0;
        im_q   <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign position_o    = pos_q;
  assign row_out_o     = row_q;
  assign re_out_o      = re_q;
  assign im_out_o      = im_q;

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= sse_pkg::PosW'(sse_pkg::MAX_ENTRIES))
    else $error("kept count beyond entry storage");

  a_keep_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && keep) |=> (kind_q == sse_pkg::KIND_ENTRY) && (kept_q == pos_q + sse_pkg::PosW'(1)))
    else $error("kept entry slot does not match counter");

  a_finish_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s2_i.finish) |=> (kept_q == '0) && out_valid_q)
    else $error("finish did not clear count or emit pointer");

endmodule

`default_nettype wire

### rtl/sparse_small_entry_drop_top.sv
// Top level of the sparse small-entry drop and compaction block.
// A result is registered in the front, square and result stages in turn after its input beat is accepted.
// Throughput: one input beat per cycle unless out_ready_i stalls; the two 32x32 squares sit in their
//   own stage and the 64-bit sum/compare with the kept counter in the last one.
// Reset: rst_ni clears config registers, column state, kept count and all valids; data registers are not reset.
`default_nettype none

module sparse_small_entry_drop_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sse_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Input stream
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic [sse_pkg::RowW-1:0]   row_index_i,
  input  wire logic signed [sse_pkg::ValW-1:0] value_re_i,
  input  wire logic signed [sse_pkg::ValW-1:0] value_im_i,
  // Result stream
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            result_kind_o,
  output logic [sse_pkg::PosW-1:0]        position_o,
  output logic [sse_pkg::RowW-1:0]        row_out_o,
  output logic signed [sse_pkg::ValW-1:0] re_out_o,
  output logic signed [sse_pkg::ValW-1:0] im_out_o
);

  sse_pkg::cfg_t cfg_q, cfg_d;
  logic          cfg_wr;
  logic [1:0]    reg_idx;

  logic          s1_valid, s1_ready, s2_valid, s2_ready;
  sse_pkg::s1_t  s1;
  sse_pkg::s2_t  s2;
  logic [sse_pkg::ValW-1:0] re_bits, im_bits;

  // Register file: a write lands in the access phase; pready is tied high.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        sse_pkg::REG_TOLERANCE: cfg_d.tolerance    = pwdata[sse_pkg::TolW-1:0];
        sse_pkg::REG_SYMMETRY:  cfg_d.sym_mode     = pwdata[1:0];
        sse_pkg::REG_COMPLEX:   cfg_d.complex_mode = pwdata[0];
        default:                cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register, zero-extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      sse_pkg::REG_TOLERANCE: prdata = {1'b0, cfg_q.tolerance};
      sse_pkg::REG_SYMMETRY:  prdata = {30'd0, cfg_q.sym_mode};
      sse_pkg::REG_COMPLEX:   prdata = {31'd0, cfg_q.complex_mode};
      default:                prdata = '0;
    endcase
  end

  // Stage 1: track columns, drop entries outside the kept triangle, take |re|, |im|.
  sse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .row_index_i (row_index_i),
    .value_re_i  (value_re_i),
    .value_im_i  (value_im_i),
    .s1_valid_o  (s1_valid),
    .s1_ready_i  (s1_ready),
    .s1_o        (s1)
  );

  // Stage 2: square both magnitudes, compare |re| for real mode.
  sse_square u_square (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_i       (s1),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_o       (s2)
  );

  // Stage 3: drop small entries and those past storage, advance or clear the kept count, hold the result beat.
  sse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s2_valid_i    (s2_valid),
    .s2_ready_o    (s2_ready),
    .s2_i          (s2),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .position_o    (position_o),
    .row_out_o     (row_out_o),
    .re_out_o      (re_bits),
    .im_out_o      (im_bits)
  );

  assign re_out_o = re_bits;
  assign im_out_o = im_bits;

endmodule

`default_nettype wire
